>>> src/dlseq_pkg.sv
package dlseq_pkg;

    // Default set size.
    localparam int MAX_JOBS_DEF = 32;

    // Field widths.
    localparam int ID_W   = 16;
    localparam int DL_W   = 10;
    localparam int PR_W   = 16;
    localparam int DONE_W = 6;
    localparam int SUM_W  = 21;

    // Saturation limits of the totals.
    localparam logic [DONE_W-1:0] DONE_MAX = {DONE_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    // Stream word widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // One stored job.
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
        logic [PR_W-1:0] pr;
    } t_job;

endpackage

>>> src/deadline_job_sequencer.sv
// Channel   Direction  Word contents
// -------   ---------  ------------------------------------------------------
// s (in)    slave      one job: id, deadline, profit; tlast closes the set
// m (out)   master     one scheduled id with final count and profit sum;
//                      tuser marks a valid id, tlast marks the last result
//
// Loading accepts one job per cycle. After the closing word, each scheduling
// pass scans the job store once (one read port with registered read data)
// and then places the best job in the ST_PLACE state. A set of n jobs
// needs n such passes plus one final scan that finds nothing before the
// first result. Each result is then read from the placed-id memory and
// registered for output in ST_EMIT_RD, and is held in ST_EMIT_WAIT for any
// output stall. Reset is synchronous and clears all control state; memories
// are not cleared. A stalled output holds its word, and no input is taken
// until the last result has been taken.
module deadline_job_sequencer #(
    parameter int MAX_JOBS = dlseq_pkg::MAX_JOBS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Bits from 0: job_id[15:0], job_deadline[25:16], job_profit[41:26].
    input  logic [dlseq_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tlast,
    output logic                                o_s_tready,
    // Bits from 0: sched_id[15:0], jobs_done[21:16], profit_sum[42:22].
    output logic [dlseq_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // Bits from 0: has_job.
    output logic                                o_m_tuser,
    output logic                                o_m_tvalid,
    output logic                                o_m_tlast,
    input  logic                                i_m_tready
);

    import dlseq_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } t_state;

    t_state r_state;

    // Job store and placed-id memory.
    t_job            r_job_mem [MAX_JOBS];
    logic [ID_W-1:0] r_pl_mem  [MAX_JOBS];
    t_job            r_job_rd;
    logic [ID_W-1:0] r_pl_rd;

    // Control and scheduling state.
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_scan;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [MAX_JOBS-1:0] r_used;
    logic [MAX_JOBS-1:0] r_slot;
    logic                r_best_vld;
    logic [IDX_W-1:0]    r_best_idx;
    t_job                r_best;
    logic [CNT_W-1:0]    r_nplaced;
    logic [CNT_W-1:0]    r_k;
    logic [DONE_W-1:0]   r_done;
    logic [SUM_W-1:0]    r_sum;
    logic                r_out_vld;
    logic                r_out_has;
    logic                r_out_last;

    t_job              in_job;
    logic              in_acc;
    logic              take_better;
    logic              slot_hit;
    logic [IDX_W-1:0]  slot_idx;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  n_sum;

    assign in_job.id = i_s_tdata[15:0];
    assign in_job.dl = i_s_tdata[25:16];
    assign in_job.pr = i_s_tdata[41:26];
    assign in_acc    = i_s_tvalid && o_s_tready;

    // A fresh read beats the current best only with strictly higher profit.
    assign take_better = r_rd_vld && !r_used[r_rd_idx]
                         && (!r_best_vld || (r_job_rd.pr > r_best.pr));

    // Latest free slot at or before the deadline; bit i stands for slot i + 1.
    always_comb begin
        slot_hit = 1'b0;
        slot_idx = '0;
        for (int i = 0; i < MAX_JOBS; i++) begin
            if (!r_slot[i] && (DL_W'(i) < r_best.dl)) begin
                slot_hit = 1'b1;
                slot_idx = IDX_W'(i);
            end
        end
    end

    // Saturating profit total.
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_best.pr);
    assign n_sum   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

    // Job store: written while loading, read during the scan.
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_count < CNT_MAX)) begin
            r_job_mem[r_count[IDX_W-1:0]] <= in_job;
        end
        if (r_state == ST_SCAN && r_scan < r_n) begin
            r_job_rd <= r_job_mem[r_scan[IDX_W-1:0]];
        end
    end

    // Placed ids: written in scheduling order, read back for output.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PLACE && slot_hit) begin
            r_pl_mem[r_nplaced[IDX_W-1:0]] <= r_best.id;
        end
        if (r_state == ST_EMIT_RD) begin
            r_pl_rd <= r_pl_mem[r_k[IDX_W-1:0]];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_n        <= '0;
            r_scan     <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
            r_used     <= '0;
            r_slot     <= '0;
            r_best_vld <= 1'b0;
            r_best_idx <= '0;
            r_best     <= '0;
            r_nplaced  <= '0;
            r_k        <= '0;
            r_done     <= '0;
            r_sum      <= '0;
            r_out_vld  <= 1'b0;
            r_out_has  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (i_s_tlast) begin
                            r_n        <= (r_count < CNT_MAX) ? r_count + 1'b1 : r_count;
                            r_count    <= '0;
                            r_scan     <= '0;
                            r_rd_vld   <= 1'b0;
                            r_used     <= '0;
                            r_slot     <= '0;
                            r_best_vld <= 1'b0;
                            r_nplaced  <= '0;
                            r_done     <= '0;
                            r_sum      <= '0;
                            r_state    <= ST_SCAN;
                        end else if (r_count < CNT_MAX) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    // Issue the next read and judge the one that came back.
                    if (r_scan < r_n) begin
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_scan[IDX_W-1:0];
                        r_scan   <= r_scan + 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (take_better) begin
                        r_best_vld <= 1'b1;
                        r_best_idx <= r_rd_idx;
                        r_best     <= r_job_rd;
                    end
                    if (r_scan == r_n && !r_rd_vld) begin
                        r_k     <= '0;
                        r_state <= r_best_vld ? ST_PLACE : ST_EMIT_RD;
                    end
                end
                ST_PLACE: begin
                    r_used[r_best_idx] <= 1'b1;
                    if (slot_hit) begin
                        r_slot[slot_idx] <= 1'b1;
                        r_nplaced        <= r_nplaced + 1'b1;
                        if (r_done != DONE_MAX) begin
                            r_done <= r_done + 1'b1;
                        end
                        r_sum <= n_sum;
                    end
                    r_scan     <= '0;
                    r_rd_vld   <= 1'b0;
                    r_best_vld <= 1'b0;
                    r_state    <= ST_SCAN;
                end
                ST_EMIT_RD: begin
                    // The read data lands in the same edge that raises valid.
                    r_out_vld  <= 1'b1;
                    r_out_has  <= (r_nplaced != '0);
                    r_out_last <= (r_nplaced == '0) || (r_k + 1'b1 == r_nplaced);
                    r_state    <= ST_EMIT_WAIT;
                end
                ST_EMIT_WAIT: begin
                    if (i_m_tready) begin
                        r_out_vld <= 1'b0;
                        if (r_out_last) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // Ports.
    assign o_s_tready = (r_state == ST_LOAD);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_has;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {(OUT_TDATA_W - ID_W - DONE_W - SUM_W)'(0),
                         r_sum, r_done, (r_out_has ? r_pl_rd : ID_W'(0))};

endmodule

>>> tb/sv/deadline_job_sequencer_tb.sv
module deadline_job_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dlseq_pkg::*;

    localparam int MAX_JOBS       = MAX_JOBS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 50;

    // One word queued for the input channel.
    typedef struct {
        t_job job;
        logic last;
    } t_job_word;

    // One expected word of the output channel.
    typedef struct {
        logic [ID_W-1:0]   sched_id;
        logic              has_job;
        logic [DONE_W-1:0] jobs_done;
        logic [SUM_W-1:0]  profit_sum;
        logic              last_result;
    } t_sched_result;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   i_s_tlast  = 1'b0;
    logic                   o_s_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   o_m_tvalid;
    logic                   o_m_tlast;
    logic                   i_m_tready = 1'b0;

    t_job_word     pending_words[$];
    t_job          held_jobs[$];
    t_sched_result sched_expect[$];
    int            errors = 0;
    int            idle_cycles = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            ready_age = 0;
    logic [15:0]   ready_pattern = 16'hFFFF;

    deadline_job_sequencer #(
        .MAX_JOBS(MAX_JOBS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_s_tvalid(i_s_tvalid),
        .i_s_tlast (i_s_tlast),
        .o_s_tready(o_s_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tvalid(o_m_tvalid),
        .o_m_tlast (o_m_tlast),
        .i_m_tready(i_m_tready)
    );

    always #5 i_clk = ~i_clk;

    // Greedy scheduling of the held set: highest profit first, equal profits in
    // arrival order, each job in the latest free slot at or before its deadline.
    function automatic void schedule_held_set();
        int                order[$];
        logic [ID_W-1:0]   placed_ids[$];
        logic [MAX_JOBS:0] slot_taken;
        logic [DONE_W-1:0] done;
        logic [SUM_W-1:0]  sum;
        logic [SUM_W:0]    acc;
        t_sched_result     r;
        int                pos;
        int                slot;
        t_job              j;
        for (int i = 0; i < held_jobs.size(); i++) begin
            pos = order.size();
            while (pos > 0 && held_jobs[order[pos-1]].pr < held_jobs[i].pr) begin
                pos--;
            end
            order.insert(pos, i);
        end
        slot_taken = '0;
        done = '0;
        sum = '0;
        foreach (order[k]) begin
            j = held_jobs[order[k]];
            slot = (j.dl > MAX_JOBS) ? MAX_JOBS : int'(j.dl);
            while (slot > 0 && slot_taken[slot]) begin
                slot--;
            end
            if (slot > 0) begin
                slot_taken[slot] = 1'b1;
                placed_ids = {placed_ids, j.id};
                if (done != DONE_MAX) begin
                    done++;
                end
                acc = sum + j.pr;
                sum = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
            end
        end
        if (placed_ids.size() == 0) begin
            r = '{sched_id: '0, has_job: 1'b0, jobs_done: '0, profit_sum: '0,
                  last_result: 1'b1};
            sched_expect = {sched_expect, r};
        end else begin
            foreach (placed_ids[k]) begin
                r = '{sched_id: placed_ids[k], has_job: 1'b1, jobs_done: done,
                      profit_sum: sum, last_result: (k == placed_ids.size() - 1)};
                sched_expect = {sched_expect, r};
            end
        end
        held_jobs.delete();
    endfunction

    task automatic queue_job(input logic [ID_W-1:0] id, input logic [DL_W-1:0] dl,
                             input logic [PR_W-1:0] pr, input logic last);
        t_job_word w;
        w.job.id = id;
        w.job.dl = dl;
        w.job.pr = pr;
        w.last = last;
        pending_words = {pending_words, w};
    endtask

    // A set of n random jobs; tight deadlines and narrow profits force contention
    // and ties, wide ones cover every bit of the fields.
    task automatic queue_random_set(input int n);
        logic wide_dl;
        logic wide_pr;
        logic [DL_W-1:0] dl;
        logic [PR_W-1:0] pr;
        wide_dl = ($urandom_range(0, 3) == 0);
        wide_pr = ($urandom_range(0, 2) != 0);
        for (int i = 0; i < n; i++) begin
            dl = wide_dl ? DL_W'($urandom_range(0, 1023)) : DL_W'($urandom_range(0, n + 1));
            pr = wide_pr ? PR_W'($urandom) : PR_W'($urandom_range(0, 3));
            queue_job(ID_W'($urandom), dl, pr, i == n - 1);
        end
    endtask

    // Input driver: bursts of words separated by random gaps.
    always @(posedge i_clk) begin
        t_job_word w;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tlast  <= 1'b0;
            i_s_tdata  <= '0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                i_s_tdata  <= {6'b0, w.job.pr, w.job.dl, w.job.id};
                i_s_tlast  <= w.last;
                i_s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Collect each accepted job and predict the run that a closing word starts.
    always @(posedge i_clk) begin
        t_job j;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            j.id = i_s_tdata[15:0];
            j.dl = i_s_tdata[25:16];
            j.pr = i_s_tdata[41:26];
            if (held_jobs.size() < MAX_JOBS) begin
                held_jobs = {held_jobs, j};
            end
            if (i_s_tlast) begin
                schedule_held_set();
            end
        end
    end

    // Output stall pattern: a rotating 16-bit mask, replaced by a randomly chosen one whenever ready_age wraps.
    always @(posedge i_clk) begin
        logic [15:0] next_pattern;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            ready_age = 0;
            ready_pattern <= 16'hFFFF;
        end else begin
            next_pattern = {ready_pattern[0], ready_pattern[15:1]};
            ready_age = ready_age + 1;
            if (ready_age == 48) begin
                ready_age = 0;
                case ($urandom_range(0, 3))
                    0: next_pattern = 16'hFFFF;
                    1: next_pattern = 16'($urandom);
                    2: next_pattern = 16'h5555;
                    default: next_pattern = 16'h000F;
                endcase
            end
            i_m_tready <= ready_pattern[0];
            ready_pattern <= next_pattern;
        end
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.sched_id    = o_m_tdata[15:0];
            got.jobs_done   = o_m_tdata[21:16];
            got.profit_sum  = o_m_tdata[42:22];
            got.has_job     = o_m_tuser;
            got.last_result = o_m_tlast;
            if (sched_expect.size() == 0) begin
                $display("%0t: unexpected result word: id %h has_job %b done %0d sum %0d last %b",
                         $time, got.sched_id, got.has_job, got.jobs_done, got.profit_sum,
                         got.last_result);
                errors++;
            end else begin
                want = sched_expect.pop_front();
                if (got.sched_id !== want.sched_id || got.has_job !== want.has_job ||
                    got.jobs_done !== want.jobs_done || got.profit_sum !== want.profit_sum ||
                    got.last_result !== want.last_result) begin
                    $display("%0t: result mismatch: expected id %h has_job %b done %0d sum %0d last %b",
                             $time, want.sched_id, want.has_job, want.jobs_done,
                             want.profit_sum, want.last_result);
                    $display("%0t:                  actual id %h has_job %b done %0d sum %0d last %b",
                             $time, got.sched_id, got.has_job, got.jobs_done, got.profit_sum,
                             got.last_result);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if (i_rst_n && ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int set_index;
        int random_jobs;
        int n;

        // Deadline zero alone gives the empty result.
        queue_job(16'h1234, 10'd0, 16'd500, 1'b1);
        // All-ones fields; the deadline is clamped to the last slot.
        queue_job(16'hFFFF, 10'd1023, 16'hFFFF, 1'b1);
        // Zero id and zero profit still count as placed.
        queue_job(16'h0000, 10'd1, 16'd0, 1'b1);
        // Equal profits in arrival order, contention, skipped jobs.
        queue_job(16'd1, 10'd2, 16'd100, 1'b0);
        queue_job(16'd2, 10'd1, 16'd100, 1'b0);
        queue_job(16'd3, 10'd2, 16'd100, 1'b0);
        queue_job(16'd4, 10'd1, 16'd300, 1'b0);
        queue_job(16'd5, 10'd3, 16'd50, 1'b0);
        queue_job(16'd6, 10'd0, 16'd900, 1'b1);
        // Deadlines beyond the slot range.
        queue_job(16'd10, 10'd40, 16'd7, 1'b0);
        queue_job(16'd11, 10'd1023, 16'd7, 1'b0);
        queue_job(16'd12, 10'd33, 16'd9, 1'b0);
        queue_job(16'd13, 10'd32, 16'd1, 1'b1);
        // Several jobs, none placeable.
        queue_job(16'd20, 10'd0, 16'd1, 1'b0);
        queue_job(16'd21, 10'd0, 16'd2, 1'b1);

        // Random sets, mostly small, with one full set and one overfull set.
        set_index = 0;
        random_jobs = 0;
        while (random_jobs < 100) begin
            if (set_index == 3) begin
                n = MAX_JOBS;
            end else if (set_index == 8) begin
                n = MAX_JOBS + 2;
            end else begin
                n = $urandom_range(1, 8);
            end
            queue_random_set(n);
            random_jobs += n;
            set_index++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word is taken and every prediction is met.
        @(negedge i_clk);
        while (pending_words.size() > 0 || i_s_tvalid || sched_expect.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0 && sched_expect.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
